// File: rtl/core/pwf_pkg.sv
package pwf_pkg;

	localparam int PIX_W   = 8;
	localparam int RGB_W   = 3 * PIX_W;
	localparam int MODE_W  = 2;
	localparam int INT_W   = 8;
	localparam int SIZE_W  = 12;
	localparam int REG_W   = 2;
	localparam int IDX_W   = 24;

	localparam int DEF_MAX_WIDTH  = 2048;
	localparam int DEF_MAX_HEIGHT = 2048;

	localparam int DIV_STEPS  = IDX_W;
	localparam int SQRT_STEPS = 9;

	localparam logic [MODE_W-1:0] MODE_GRAY    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EMBOSS  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SOBEL   = 2'd3;

	localparam logic [REG_W-1:0] REG_MODE      = 2'd0;
	localparam logic [REG_W-1:0] REG_INTENSITY = 2'd1;
	localparam logic [REG_W-1:0] REG_WIDTH     = 2'd2;
	localparam logic [REG_W-1:0] REG_HEIGHT    = 2'd3;

	localparam logic [MODE_W-1:0] RST_MODE      = MODE_GRAY;
	localparam logic [INT_W-1:0]  RST_INTENSITY = 8'd5;
	localparam logic [SIZE_W-1:0] RST_WIDTH     = 12'd640;
	localparam logic [SIZE_W-1:0] RST_HEIGHT    = 12'd480;

	localparam int GRAY_B     = 114;
	localparam int GRAY_G     = 587;
	localparam int GRAY_R     = 299;
	localparam int GRAY_DIV   = 1000;
	localparam int GRAY_RECIP = 1049;
	localparam int GRAY_SHIFT = 20;
	localparam int SHARP_CTR  = 4;

	typedef struct packed {
		logic accept;
		logic shift;
		logic div_start;
		logic div_step;
		logic sum;
		logic mul;
		logic clmp;
		logic sqr;
		logic sqrt_step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic emit;
	} stat_t;

endpackage

// File: rtl/core/pwf_if.sv
interface pwf_pix_in_if;
	import pwf_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] blue_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] red_in;
	logic             pad;
	modport source (output valid, blue_in, green_in, red_in, pad, input ready);
	modport sink (input valid, blue_in, green_in, red_in, pad, output ready);
endinterface

interface pwf_pix_out_if;
	import pwf_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] blue_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] red_out;
	logic             frame_end;
	modport source (output valid, blue_out, green_out, red_out, frame_end, input ready);
	modport sink (input valid, blue_out, green_out, red_out, frame_end, output ready);
endinterface

interface pwf_cfg_if;
	import pwf_pkg::*;
	logic              valid;
	logic              ready;
	logic [REG_W-1:0]  index;
	logic [SIZE_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/pwf_ram.sv
module pwf_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/core/pwf_lane.sv
module pwf_lane (
	input  logic                              clk,
	input  pwf_pkg::cmd_t                     cmd,
	input  logic [pwf_pkg::MODE_W-1:0]        mode,
	input  logic signed [pwf_pkg::INT_W-1:0]  k,
	input  logic                              border,
	input  logic [8:0][pwf_pkg::PIX_W-1:0]    nb,
	output logic [pwf_pkg::PIX_W-1:0]         res
);
	import pwf_pkg::*;

	logic [9:0]         cross_q;
	logic signed [11:0] emb_q, gx_q, gy_q;
	logic [PIX_W-1:0]   c_q;
	logic signed [17:0] sharp_q;
	logic signed [19:0] embp_q, gxp_q, gyp_q;
	logic [PIX_W-1:0]   keep_q, gxc_q, gyc_q;
	logic [17:0]        n_q, root_q, trial;
	logic [16:0]        bit_q;
	logic signed [8:0]  kc;

	function automatic logic signed [11:0] ext(input logic [PIX_W-1:0] v);
		return $signed({4'b0, v});
	endfunction

	function automatic logic [PIX_W-1:0] clamp(input logic signed [19:0] v);
		logic [PIX_W-1:0] r;
		if (v < 0) r = '0;
		else if (v > 20'sd255) r = '1;
		else r = v[PIX_W-1:0];
		return r;
	endfunction

	assign kc = $signed({k[INT_W-1], k}) + 9'(SHARP_CTR);
	assign trial = root_q + 18'(bit_q);

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			c_q     <= nb[4];
			cross_q <= 10'(nb[1]) + 10'(nb[7]) + 10'(nb[3]) + 10'(nb[5]);
			emb_q   <= ext(nb[5]) + ext(nb[7]) + (ext(nb[8]) <<< 1)
			           - ext(nb[3]) - ext(nb[1]) - (ext(nb[0]) <<< 1);
			gx_q    <= ext(nb[2]) + (ext(nb[5]) <<< 1) + ext(nb[8])
			           - ext(nb[0]) - (ext(nb[3]) <<< 1) - ext(nb[6]);
			gy_q    <= ext(nb[0]) + (ext(nb[1]) <<< 1) + ext(nb[2])
			           - ext(nb[6]) - (ext(nb[7]) <<< 1) - ext(nb[8]);
		end
		if (cmd.mul) begin
			sharp_q <= 18'(kc) * $signed({10'b0, c_q}) - $signed({8'b0, cross_q});
			embp_q  <= 20'(k) * 20'(emb_q) + $signed({12'b0, c_q});
			gxp_q   <= 20'(k) * 20'(gx_q);
			gyp_q   <= 20'(k) * 20'(gy_q);
		end
		if (cmd.clmp) begin
			if (border) begin
				keep_q <= c_q;
				gxc_q  <= c_q;
				gyc_q  <= c_q;
			end else begin
				keep_q <= (mode == MODE_EMBOSS) ? clamp(embp_q) : clamp(20'(sharp_q));
				gxc_q  <= clamp(gxp_q);
				gyc_q  <= clamp(gyp_q);
			end
		end
		if (cmd.sqr) begin
			n_q    <= 18'(gxc_q) * 18'(gxc_q) + 18'(gyc_q) * 18'(gyc_q);
			root_q <= '0;
			bit_q  <= 17'h10000;
		end else if (cmd.sqrt_step) begin
			if (n_q >= trial) begin
				n_q    <= n_q - trial;
				root_q <= (root_q >> 1) + 18'(bit_q);
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_comb begin
		if (mode == MODE_SOBEL) begin
			res = (root_q > 18'd255) ? '1 : root_q[PIX_W-1:0];
		end else begin
			res = keep_q;
		end
	end
endmodule

// File: rtl/core/pwf_ctrl.sv
module pwf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pwf_pkg::stat_t stat,
	output pwf_pkg::cmd_t  cmd
);
	import pwf_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SHIFT = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_SUM   = 4'd3;
	localparam logic [3:0] S_MUL   = 4'd4;
	localparam logic [3:0] S_CLMP  = 4'd5;
	localparam logic [3:0] S_SQR   = 4'd6;
	localparam logic [3:0] S_SQRT  = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				if (stat.emit) begin
					cmd.div_start = 1'b1;
					cnt_d         = '0;
					state_d       = S_DIV;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_CLMP;
			end
			S_CLMP: begin
				cmd.clmp = 1'b1;
				state_d  = S_SQR;
			end
			S_SQR: begin
				cmd.sqr = 1'b1;
				cnt_d   = '0;
				state_d = S_SQRT;
			end
			S_SQRT: begin
				cmd.sqrt_step = 1'b1;
				cnt_d         = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	a_accept_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_SHIFT))
		else $error("accepted request not followed by shift");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && !stat.emit) |=> (state_q == S_IDLE))
		else $error("non-emitting request did not return to idle");

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) |=> (state_q == S_SUM))
		else $error("divider did not finish on time");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("result overwrote a pending output");

	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(out_ready))
		else $error("output dropped without ready");
endmodule

// File: rtl/core/pwf_dp.sv
module pwf_dp #(
	parameter int MAX_WIDTH  = pwf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pwf_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pwf_pkg::cmd_t              cmd,
	output pwf_pkg::stat_t             stat,
	input  logic [pwf_pkg::PIX_W-1:0]  blue_in,
	input  logic [pwf_pkg::PIX_W-1:0]  green_in,
	input  logic [pwf_pkg::PIX_W-1:0]  red_in,
	input  logic                       pad,
	input  logic                       cfg_we,
	input  logic [pwf_pkg::REG_W-1:0]  cfg_index,
	input  logic [pwf_pkg::SIZE_W-1:0] cfg_data,
	output logic [pwf_pkg::PIX_W-1:0]  blue_out,
	output logic [pwf_pkg::PIX_W-1:0]  green_out,
	output logic [pwf_pkg::PIX_W-1:0]  red_out,
	output logic                       frame_end
);
	import pwf_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int CMP_W = ((CW > SIZE_W) ? CW : SIZE_W) + 1;
	localparam int WCAP  = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;
	localparam int HCAP  = (MAX_HEIGHT > 4095) ? 4095 : MAX_HEIGHT;
	localparam logic [SIZE_W-1:0] WCAP_V = SIZE_W'(WCAP);
	localparam logic [SIZE_W-1:0] HCAP_V = SIZE_W'(HCAP);

	logic [MODE_W-1:0]   mode_q;
	logic [INT_W-1:0]    int_q;
	logic [SIZE_W-1:0]   fw_q, fh_q, w, h;
	logic [CW-1:0]       in_column_q;
	logic [1:0]          in_row_q;
	logic [IDX_W-1:0]    out_index_q, hw_q, quo_q;
	logic [SIZE_W-1:0]   rem_q;
	logic [SIZE_W:0]     trial;
	logic                trial_ge;
	logic                border_q, last_q;
	logic [RGB_W-1:0]    px_q, up, mid;
	logic [2*RGB_W-1:0]  rdata;
	logic [2:0][2:0][RGB_W-1:0] win_q;
	logic [2:0][8:0][PIX_W-1:0] lane_nb;
	logic [2:0][PIX_W-1:0]      lane_res;
	logic [17:0]         gsum_q;
	logic [28:0]         gp_q;
	logic [8:0]          q0, q0_fix;
	logic [PIX_W-1:0]    gray_q;
	logic [PIX_W-1:0]    blue_q, green_q, red_q;
	logic                frame_end_q;

	assign w = (fw_q == '0) ? SIZE_W'(1) : ((fw_q > WCAP_V) ? WCAP_V : fw_q);
	assign h = (fh_q == '0) ? SIZE_W'(1) : ((fh_q > HCAP_V) ? HCAP_V : fh_q);

	assign stat.emit = (in_row_q == 2'd2) || (in_row_q == 2'd1 && in_column_q != '0);

	// config registers and stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= RST_MODE;
			int_q       <= RST_INTENSITY;
			fw_q        <= RST_WIDTH;
			fh_q        <= RST_HEIGHT;
			in_column_q <= '0;
			in_row_q    <= '0;
			out_index_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:      mode_q <= cfg_data[MODE_W-1:0];
					REG_INTENSITY: int_q  <= cfg_data[INT_W-1:0];
					REG_WIDTH:     fw_q   <= cfg_data;
					REG_HEIGHT:    fh_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.shift) begin
				if (CMP_W'(in_column_q) + CMP_W'(1) >= CMP_W'(w)) begin
					in_column_q <= '0;
					if (in_row_q != 2'd2) begin
						in_row_q <= in_row_q + 2'd1;
					end
				end else begin
					in_column_q <= in_column_q + 1'b1;
				end
			end
			if (cmd.load) begin
				if (last_q) begin
					in_column_q <= '0;
					in_row_q    <= '0;
					out_index_q <= '0;
				end else begin
					out_index_q <= out_index_q + 1'b1;
				end
			end
		end
	end

	pwf_ram #(
		.WIDTH(2 * RGB_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (cmd.shift),
		.waddr (in_column_q),
		.wdata ({mid, px_q}),
		.raddr (in_column_q),
		.rdata (rdata)
	);

	assign up  = rdata[2*RGB_W-1:RGB_W];
	assign mid = rdata[RGB_W-1:0];

	assign trial    = {rem_q, quo_q[IDX_W-1]};
	assign trial_ge = (trial >= (SIZE_W+1)'(w));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			px_q <= pad ? '0 : {red_in, green_in, blue_in};
		end
		if (cmd.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= up;
			win_q[1][2] <= mid;
			win_q[2][2] <= px_q;
			hw_q        <= IDX_W'(h) * IDX_W'(w);
		end
		// restoring divide of the output index: row in quo_q, column in rem_q
		if (cmd.div_start) begin
			quo_q <= out_index_q;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? SIZE_W'(trial - (SIZE_W+1)'(w)) : trial[SIZE_W-1:0];
			quo_q <= {quo_q[IDX_W-2:0], trial_ge};
		end
		if (cmd.sum) begin
			border_q <= (quo_q == '0) || ((IDX_W+1)'(quo_q) + 1'b1 >= (IDX_W+1)'(h))
			            || (rem_q == '0) || ((SIZE_W+1)'(rem_q) + 1'b1 >= (SIZE_W+1)'(w));
			last_q   <= ((IDX_W+1)'(out_index_q) + 1'b1 >= (IDX_W+1)'(hw_q));
			gsum_q   <= 18'(GRAY_B * win_q[1][1][PIX_W-1:0]
			               + GRAY_G * win_q[1][1][2*PIX_W-1:PIX_W]
			               + GRAY_R * win_q[1][1][RGB_W-1:2*PIX_W]);
		end
		if (cmd.mul) begin
			gp_q <= 29'(gsum_q * GRAY_RECIP);
		end
		if (cmd.clmp) begin
			gray_q <= q0_fix[PIX_W-1:0];
		end
		if (cmd.load) begin
			blue_q      <= (mode_q == MODE_GRAY) ? gray_q : lane_res[0];
			green_q     <= (mode_q == MODE_GRAY) ? gray_q : lane_res[1];
			red_q       <= (mode_q == MODE_GRAY) ? gray_q : lane_res[2];
			frame_end_q <= last_q;
		end
	end

	// reciprocal estimate is exact or one high
	assign q0     = 9'(gp_q >> GRAY_SHIFT);
	assign q0_fix = (20'(q0) * 20'(GRAY_DIV) > 20'(gsum_q)) ? q0 - 9'd1 : q0;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					lane_nb[ch][r*3+c] = win_q[r][c][ch*PIX_W +: PIX_W];
				end
			end
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		pwf_lane u_lane (
			.clk    (clk),
			.cmd    (cmd),
			.mode   (mode_q),
			.k      ($signed(int_q)),
			.border (border_q),
			.nb     (lane_nb[ch]),
			.res    (lane_res[ch])
		);
	end

	assign blue_out  = blue_q;
	assign green_out = green_q;
	assign red_out   = red_q;
	assign frame_end = frame_end_q;
endmodule

// File: rtl/core/pixel_window_filter_3x3.sv
// 3x3 window filter for raster-order RGB pixels (grayscale, sharpen, emboss,
// sobel magnitude). Pixels enter on pix_in, one request per pixel; after the
// last row of a frame send frame_width+1 requests with pad set to flush it.
// Results leave on pix_out, each pixel one row plus one pixel after it came
// in; frame_end marks the last pixel of the frame.
// Configuration is written on cfg (index 0 mode, 1 intensity, 2 width,
// 3 height), always ready; write it only while the block is idle.
// Steps: a request that produces no result is accepted, shifted into the
// window and returns to idle. One that produces a result then runs the
// bit-serial divide that turns the output index into row and column, the
// filter arithmetic (sum, multiply, clamp, square), the per-channel square
// root iteration and the hand-off; no new request is taken until idle.
// The finished result sits in an output register; the next pixel is taken
// while it waits. A stalled receiver holds the block once a second result is
// ready. Reset returns the control to idle, clears the row, column and output
// counters and loads the register defaults; line stores are not cleared.
module pixel_window_filter_3x3 #(
	parameter int MAX_WIDTH  = pwf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pwf_pkg::DEF_MAX_HEIGHT
) (
	input  logic          clk,
	input  logic          arst_n,
	pwf_pix_in_if.sink    pix_in,
	pwf_pix_out_if.source pix_out,
	pwf_cfg_if.sink       cfg
);
	import pwf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg.ready = 1'b1;

	pwf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pwf_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.blue_in   (pix_in.blue_in),
		.green_in  (pix_in.green_in),
		.red_in    (pix_in.red_in),
		.pad       (pix_in.pad),
		.cfg_we    (cfg.valid & cfg.ready),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.blue_out  (pix_out.blue_out),
		.green_out (pix_out.green_out),
		.red_out   (pix_out.red_out),
		.frame_end (pix_out.frame_end)
	);
endmodule
